// ----- design/stereo_harmonic_exciter_top_defines.svh -----
// ----------------------------------------------------------------------------
// Stereo harmonic exciter assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef STEREO_HARMONIC_EXCITER_TOP_DEFINES_SVH
`define STEREO_HARMONIC_EXCITER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("exciter check failed");

// The consequent must hold in the cycle after the antecedent.
`define SHE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("exciter check failed");

`endif

// ----- design/she_pkg.sv -----
// ----------------------------------------------------------------------------
// she_pkg
// Shared types, constants and the CORDIC angle table of the exciter.
// ----------------------------------------------------------------------------
package she_pkg;

	localparam int SAMPLE_BITS     = 24;
	localparam int SINE_ITERATIONS = 16;

	localparam int FIELD_W   = 24;
	localparam int COEF_W    = 24;
	localparam int OPND_W    = 33;
	localparam int PROD_W    = COEF_W + OPND_W;
	localparam int ACC_W     = 64;
	localparam int HIST_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int ANGLE_STEPS = 24;
	localparam int ANGLE_IDX_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_ONE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_TWO = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ODD_GAIN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EVEN_GAIN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WET_LEVEL    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DRY_LEVEL    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO       = 3'd7;

	localparam logic signed [COEF_W-1:0] RST_FILTER_GAIN  = 24'sd1464217;
	localparam logic signed [COEF_W-1:0] RST_FEEDBACK_ONE = 24'sd1607310;
	localparam logic signed [COEF_W-1:0] RST_FEEDBACK_TWO = -24'sd653209;
	localparam logic signed [COEF_W-1:0] RST_ODD_GAIN     = 24'sd1572864;

	// Angles in Q.29 radians.
	localparam logic [33:0] TWO_PI_Q29     = 34'd3373259426;
	localparam logic signed [34:0] PI_Q29      = 35'sd1686629713;
	localparam logic signed [34:0] HALF_PI_Q29 = 35'sd843314856;
	localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;

	typedef struct packed {
		logic signed [COEF_W-1:0] filter_gain;
		logic signed [COEF_W-1:0] feedback_one;
		logic signed [COEF_W-1:0] feedback_two;
		logic signed [COEF_W-1:0] odd_gain;
		logic signed [COEF_W-1:0] even_gain;
		logic signed [COEF_W-1:0] wet_level;
		logic signed [COEF_W-1:0] dry_level;
		logic                     stereo_enable;
	} cfg_t;

	typedef struct packed {
		logic en;
		logic clear;
		logic shift;
	} mac_op_t;

	typedef struct packed {
		logic                     start;
		logic signed [HIST_W-1:0] angle;
	} sine_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [HIST_W-1:0] value;
	} sine_rsp_t;

	function automatic logic [31:0] angle_step(input logic [ANGLE_IDX_W-1:0] idx);
		logic [31:0] v;
		unique case (idx)
			5'd0:  v = 32'd843314856;
			5'd1:  v = 32'd497837829;
			5'd2:  v = 32'd263043836;
			5'd3:  v = 32'd133525158;
			5'd4:  v = 32'd67021686;
			5'd5:  v = 32'd33543515;
			5'd6:  v = 32'd16775850;
			5'd7:  v = 32'd8388437;
			5'd8:  v = 32'd4194282;
			5'd9:  v = 32'd2097149;
			5'd10: v = 32'd1048575;
			5'd11: v = 32'd524287;
			5'd12: v = 32'd262143;
			5'd13: v = 32'd131071;
			5'd14: v = 32'd65535;
			5'd15: v = 32'd32767;
			5'd16: v = 32'd16383;
			5'd17: v = 32'd8191;
			5'd18: v = 32'd4095;
			5'd19: v = 32'd2047;
			5'd20: v = 32'd1023;
			5'd21: v = 32'd511;
			5'd22: v = 32'd255;
			5'd23: v = 32'd127;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- design/she_in_if.sv -----
// ----------------------------------------------------------------------------
// she_in_if
// Input channel: one stereo sample pair per transfer.
// ----------------------------------------------------------------------------
interface she_in_if;
	logic valid;
	logic ready;
	logic signed [she_pkg::FIELD_W-1:0] left_in;
	logic signed [she_pkg::FIELD_W-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink (input valid, input left_in, input right_in, output ready);
endinterface

// ----- design/she_out_if.sv -----
// ----------------------------------------------------------------------------
// she_out_if
// Output channel: one processed sample pair and clip flag per transfer.
// ----------------------------------------------------------------------------
interface she_out_if;
	logic valid;
	logic ready;
	logic signed [she_pkg::FIELD_W-1:0] left_out;
	logic signed [she_pkg::FIELD_W-1:0] right_out;
	logic clipped;

	modport source (output valid, output left_out, output right_out, output clipped,
		input ready);
	modport sink (input valid, input left_out, input right_out, input clipped,
		output ready);
endinterface

// ----- design/stereo_harmonic_exciter_top.sv -----
// ----------------------------------------------------------------------------
// stereo_harmonic_exciter_top
// Stereo highpass exciter with sine and rectified harmonics and wet/dry mix.
// ----------------------------------------------------------------------------
// The block works on one sample pair at a time, channel by channel, and the
// second channel is processed only in stereo. Its pace is set by the single
// shared 24 x 33 bit multiplier, which serves eight products per channel, and
// by the iterative sine unit (six reduction steps, one fold step,
// SINE_ITERATIONS CORDIC steps and a registered completion flag). The input is
// ready only while the sequencer is idle; a finished pair waits in the output
// register while the next pair is taken in, and the sequencer holds its next
// result until that register is free.
module stereo_harmonic_exciter_top #(
	parameter int SAMPLE_BITS     = she_pkg::SAMPLE_BITS,
	parameter int SINE_ITERATIONS = she_pkg::SINE_ITERATIONS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	she_in_if.sink                        samples,
	she_out_if.source                     results,
	input  logic                          cfg_we,
	input  logic [she_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [she_pkg::COEF_W-1:0]    cfg_data
);

`include "stereo_harmonic_exciter_top_defines.svh"

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_F0    = 4'd1;
	localparam logic [3:0] ST_F1    = 4'd2;
	localparam logic [3:0] ST_F2    = 4'd3;
	localparam logic [3:0] ST_Y     = 4'd4;
	localparam logic [3:0] ST_EVEN  = 4'd5;
	localparam logic [3:0] ST_EVR   = 4'd6;
	localparam logic [3:0] ST_SWAIT = 4'd7;
	localparam logic [3:0] ST_ODD   = 4'd8;
	localparam logic [3:0] ST_ODR   = 4'd9;
	localparam logic [3:0] ST_O0    = 4'd10;
	localparam logic [3:0] ST_O1    = 4'd11;
	localparam logic [3:0] ST_O2    = 4'd12;
	localparam logic [3:0] ST_OUT   = 4'd13;
	localparam logic [3:0] ST_DONE  = 4'd14;

	localparam int FW = she_pkg::FIELD_W;
	localparam int HW = she_pkg::HIST_W;
	localparam int AW = she_pkg::ACC_W;
	localparam int OW = she_pkg::OPND_W;
	localparam int RW = AW - 20;

	localparam logic signed [AW-1:0] HALF_20 = AW'(64'sd1 <<< 19);
	localparam logic signed [AW-1:0] HALF_27 = AW'(64'sd1 <<< 26);
	localparam logic signed [RW-1:0] Y_HI    = RW'((64'sd1 <<< (HW - 1)) - 64'sd1);
	localparam logic signed [RW-1:0] Y_LO    = RW'(-(64'sd1 <<< (HW - 1)));
	localparam logic signed [RW-1:0] SAT_HI  = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [RW-1:0] SAT_LO  = RW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

	she_pkg::cfg_t      cfg;
	she_pkg::mac_op_t   mac_op;
	she_pkg::sine_req_t sine_req;
	she_pkg::sine_rsp_t sine_rsp;

	logic [3:0]                 state_q;
	logic                       ch_q;
	logic signed [FW-1:0]       x_q   [2];
	logic signed [FW-1:0]       ih0_q [2];
	logic signed [FW-1:0]       ih1_q [2];
	logic signed [HW-1:0]       oh0_q [2];
	logic signed [HW-1:0]       oh1_q [2];
	logic signed [HW-1:0]       y_q;
	logic signed [HW-1:0]       s_q;
	logic signed [36:0]         p_q;
	logic signed [FW-1:0]       res_q [2];
	logic                       clip_q;
	logic                       out_valid_q;
	logic signed [FW-1:0]       left_out_q;
	logic signed [FW-1:0]       right_out_q;
	logic                       clipped_q;

	logic signed [AW-1:0]       acc;
	logic signed [she_pkg::COEF_W-1:0] coef;
	logic signed [OW-1:0]       opnd;
	logic signed [FW-1:0]       x_cur;
	logic signed [26:0]         hp_in;
	logic signed [HW-1:0]       e_cur;
	logic signed [RW-1:0]       rnd20;
	logic signed [36:0]         rnd27;
	logic signed [HW-1:0]       y_sat;
	logic signed [RW-1:0]       o_sat;
	logic                       o_clip;
	logic                       out_free;

	she_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	she_mac u_mac (
		.clk  (clk),
		.op   (mac_op),
		.coef (coef),
		.opnd (opnd),
		.acc  (acc)
	);

	she_sine #(
		.SINE_ITERATIONS (SINE_ITERATIONS)
	) u_sine (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sine_req),
		.rsp    (sine_rsp)
	);

	always_comb begin
		x_cur = x_q[ch_q];
		hp_in = 27'(x_cur) - (27'(ih0_q[ch_q]) <<< 1) + 27'(ih1_q[ch_q]);
		e_cur = (y_q > 0) ? y_q : '0;
		rnd20 = RW'((acc + HALF_20) >>> 20);
		rnd27 = 37'((acc + HALF_27) >>> 27);
		if (rnd20 > Y_HI) begin
			y_sat = HW'(Y_HI);
		end else if (rnd20 < Y_LO) begin
			y_sat = HW'(Y_LO);
		end else begin
			y_sat = HW'(rnd20);
		end
		o_clip = 1'b0;
		if (rnd20 > SAT_HI) begin
			o_sat  = SAT_HI;
			o_clip = 1'b1;
		end else if (rnd20 < SAT_LO) begin
			o_sat  = SAT_LO;
			o_clip = 1'b1;
		end else begin
			o_sat = rnd20;
		end
		out_free = !out_valid_q || results.ready;
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mac_op = '0;
		coef   = cfg.wet_level;
		opnd   = '0;
		unique case (state_q)
			ST_F0: begin
				mac_op = '{en: 1'b1, clear: 1'b1, shift: 1'b0};
				coef   = cfg.feedback_one;
				opnd   = OW'(oh0_q[ch_q]);
			end
			ST_F1: begin
				mac_op = '{en: 1'b1, clear: 1'b0, shift: 1'b0};
				coef   = cfg.feedback_two;
				opnd   = OW'(oh1_q[ch_q]);
			end
			ST_F2: begin
				mac_op = '{en: 1'b1, clear: 1'b0, shift: 1'b0};
				coef   = cfg.filter_gain;
				opnd   = OW'(hp_in);
			end
			ST_EVEN: begin
				mac_op = '{en: 1'b1, clear: 1'b1, shift: 1'b0};
				coef   = cfg.even_gain;
				opnd   = OW'(e_cur);
			end
			ST_ODD: begin
				mac_op = '{en: 1'b1, clear: 1'b1, shift: 1'b0};
				coef   = cfg.odd_gain;
				opnd   = OW'(s_q);
			end
			ST_O0: begin
				mac_op = '{en: 1'b1, clear: 1'b1, shift: 1'b0};
				coef   = cfg.dry_level;
				opnd   = OW'(x_cur);
			end
			ST_O1: begin
				// Low partial product of the wide processed value, taken unsigned.
				mac_op = '{en: 1'b1, clear: 1'b0, shift: 1'b0};
				coef   = cfg.wet_level;
				opnd   = $signed({15'b0, p_q[17:0]});
			end
			ST_O2: begin
				mac_op = '{en: 1'b1, clear: 1'b0, shift: 1'b1};
				coef   = cfg.wet_level;
				opnd   = OW'(p_q >>> 18);
			end
			default: ;
		endcase
	end

	assign sine_req.start = (state_q == ST_EVEN);
	assign sine_req.angle = y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < 2; c++) begin
				ih0_q[c] <= '0;
				ih1_q[c] <= '0;
				oh0_q[c] <= '0;
				oh1_q[c] <= '0;
			end
		end else begin
			if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						ch_q    <= 1'b0;
						state_q <= ST_F0;
					end
				end
				ST_F0:  state_q <= ST_F1;
				ST_F1:  state_q <= ST_F2;
				ST_F2:  state_q <= ST_Y;
				ST_Y:   state_q <= ST_EVEN;
				ST_EVEN: state_q <= ST_EVR;
				ST_EVR: state_q <= ST_SWAIT;
				ST_SWAIT: begin
					if (sine_rsp.done) begin
						state_q <= ST_ODD;
					end
				end
				ST_ODD: state_q <= ST_ODR;
				ST_ODR: state_q <= ST_O0;
				ST_O0:  state_q <= ST_O1;
				ST_O1:  state_q <= ST_O2;
				ST_O2:  state_q <= ST_OUT;
				ST_OUT: begin
					ih1_q[ch_q] <= ih0_q[ch_q];
					ih0_q[ch_q] <= x_cur;
					oh1_q[ch_q] <= oh0_q[ch_q];
					oh0_q[ch_q] <= y_q;
					if (!ch_q && cfg.stereo_enable) begin
						ch_q    <= 1'b1;
						state_q <= ST_F0;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q[0]   <= samples.left_in;
				x_q[1]   <= samples.right_in;
				res_q[1] <= '0;
				clip_q   <= 1'b0;
			end
			ST_Y:     y_q <= y_sat;
			ST_EVR:   p_q <= 37'(x_cur) + 37'(rnd20);
			ST_SWAIT: s_q <= sine_rsp.value;
			ST_ODR:   p_q <= p_q + rnd27;
			ST_OUT: begin
				res_q[ch_q] <= o_sat[FW-1:0];
				clip_q      <= clip_q | o_clip;
			end
			ST_DONE: begin
				if (out_free) begin
					left_out_q  <= res_q[0];
					right_out_q <= res_q[1];
					clipped_q   <= clip_q;
				end
			end
			default: ;
		endcase
	end

	assign samples.ready     = (state_q == ST_IDLE);
	assign results.valid     = out_valid_q;
	assign results.left_out  = left_out_q;
	assign results.right_out = right_out_q;
	assign results.clipped   = clipped_q;

	`SHE_ASSERT_NEXT(a_accept_starts, clk, arst_n, samples.valid && samples.ready, state_q == ST_F0)
	`SHE_ASSERT_SAME(a_busy_not_ready, clk, arst_n, state_q != ST_IDLE, !samples.ready)
	`SHE_ASSERT_SAME(a_result_drop_taken, clk, arst_n, $fell(out_valid_q), $past(results.ready))

endmodule

// ----- design/she_regs.sv -----
// ----------------------------------------------------------------------------
// she_regs
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module she_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              we,
	input  logic [she_pkg::CFG_IDX_W-1:0]     index,
	input  logic [she_pkg::COEF_W-1:0]        data,
	output she_pkg::cfg_t                     cfg
);

	she_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_gain   <= she_pkg::RST_FILTER_GAIN;
			cfg_q.feedback_one  <= she_pkg::RST_FEEDBACK_ONE;
			cfg_q.feedback_two  <= she_pkg::RST_FEEDBACK_TWO;
			cfg_q.odd_gain      <= she_pkg::RST_ODD_GAIN;
			cfg_q.even_gain     <= '0;
			cfg_q.wet_level     <= '0;
			cfg_q.dry_level     <= '0;
			cfg_q.stereo_enable <= 1'b0;
		end else if (we) begin
			unique case (index)
				she_pkg::REG_FILTER_GAIN:  cfg_q.filter_gain  <= data;
				she_pkg::REG_FEEDBACK_ONE: cfg_q.feedback_one <= data;
				she_pkg::REG_FEEDBACK_TWO: cfg_q.feedback_two <= data;
				she_pkg::REG_ODD_GAIN:     cfg_q.odd_gain     <= data;
				she_pkg::REG_EVEN_GAIN:    cfg_q.even_gain    <= data;
				she_pkg::REG_WET_LEVEL:    cfg_q.wet_level    <= data;
				she_pkg::REG_DRY_LEVEL:    cfg_q.dry_level    <= data;
				she_pkg::REG_STEREO:       cfg_q.stereo_enable <= data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/she_mac.sv -----
// ----------------------------------------------------------------------------
// she_mac
// Shared multiply-accumulate unit: coefficient times operand into a wide sum.
// ----------------------------------------------------------------------------
module she_mac (
	input  logic                                clk,
	input  she_pkg::mac_op_t                    op,
	input  logic signed [she_pkg::COEF_W-1:0]   coef,
	input  logic signed [she_pkg::OPND_W-1:0]   opnd,
	output logic signed [she_pkg::ACC_W-1:0]    acc
);

	logic signed [she_pkg::PROD_W-1:0] prod;
	logic signed [she_pkg::ACC_W-1:0]  prod_ext;
	logic signed [she_pkg::ACC_W-1:0]  addend;
	logic signed [she_pkg::ACC_W-1:0]  acc_q;

	assign prod     = coef * opnd;
	assign prod_ext = she_pkg::ACC_W'(prod);
	// The shifted form carries the upper partial product of a wide operand.
	assign addend   = op.shift ? (prod_ext <<< 18) : prod_ext;

	always_ff @(posedge clk) begin
		if (op.en) begin
			acc_q <= (op.clear ? '0 : acc_q) + addend;
		end
	end

	assign acc = acc_q;

endmodule

// ----- design/she_sine.sv -----
// ----------------------------------------------------------------------------
// she_sine
// Iterative sine: modulo-2pi reduction by shift-subtract, fold, then CORDIC.
// ----------------------------------------------------------------------------
module she_sine #(
	parameter int SINE_ITERATIONS = she_pkg::SINE_ITERATIONS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  she_pkg::sine_req_t   req,
	output she_pkg::sine_rsp_t   rsp
);

	localparam int IW = (SINE_ITERATIONS > 1) ? $clog2(SINE_ITERATIONS) : 1;
	localparam logic [IW-1:0] LAST_ITER = IW'(SINE_ITERATIONS - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MOD  = 2'd1;
	localparam logic [1:0] S_FIX  = 2'd2;
	localparam logic [1:0] S_ROT  = 2'd3;

	logic [1:0]         st_q;
	logic               neg_q;
	logic [37:0]        a_q;
	logic [2:0]         k_q;
	logic signed [34:0] z_q;
	logic signed [33:0] cx_q;
	logic signed [33:0] cy_q;
	logic [IW-1:0]      i_q;
	logic               done_q;

	logic signed [37:0] v_in;
	logic [37:0]        csh;
	logic [33:0]        m_raw;
	logic [33:0]        m_pos;
	logic signed [34:0] r0;
	logic signed [34:0] r1;
	logic signed [34:0] r2;
	logic signed [33:0] dx;
	logic signed [33:0] dy;
	logic signed [34:0] step;

	always_comb begin
		v_in  = {req.angle, 6'b0};
		csh   = {4'b0, she_pkg::TWO_PI_Q29} << k_q;
		m_raw = a_q[33:0];
		// A negative angle reduces to the complement, except on an exact multiple.
		m_pos = (neg_q && (m_raw != '0)) ? (she_pkg::TWO_PI_Q29 - m_raw) : m_raw;
		r0    = $signed({1'b0, m_pos});
		r1    = (r0 >= she_pkg::PI_Q29) ? (r0 - $signed({1'b0, she_pkg::TWO_PI_Q29})) : r0;
		if (r1 > she_pkg::HALF_PI_Q29) begin
			r2 = she_pkg::PI_Q29 - r1;
		end else if (r1 < -she_pkg::HALF_PI_Q29) begin
			r2 = -she_pkg::PI_Q29 - r1;
		end else begin
			r2 = r1;
		end
		dx   = cy_q >>> i_q;
		dy   = cx_q >>> i_q;
		step = $signed({3'b0, she_pkg::angle_step(she_pkg::ANGLE_IDX_W'(i_q))});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (req.start) begin
						st_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (k_q == 3'd0) begin
						st_q <= S_FIX;
					end
				end
				S_FIX: st_q <= S_ROT;
				S_ROT: begin
					if (i_q == LAST_ITER) begin
						st_q   <= S_IDLE;
						done_q <= 1'b1;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				neg_q <= v_in[37];
				a_q   <= v_in[37] ? (38'd0 - v_in) : v_in;
				k_q   <= 3'd5;
			end
			S_MOD: begin
				if (a_q >= csh) begin
					a_q <= a_q - csh;
				end
				k_q <= k_q - 3'd1;
			end
			S_FIX: begin
				z_q  <= r2 <<< 1;
				cx_q <= she_pkg::CORDIC_K_Q30;
				cy_q <= '0;
				i_q  <= '0;
			end
			S_ROT: begin
				if (z_q >= 0) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					z_q  <= z_q - step;
				end else begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					z_q  <= z_q + step;
				end
				i_q <= i_q + IW'(1);
			end
			default: ;
		endcase
	end

	assign rsp.done  = done_q;
	assign rsp.value = cy_q[31:0];

endmodule
